@@ design/register_pool_allocator_with_spill_defines.svh @@
// Assertion macros for the register pool allocator.
// Used by register_pool_allocator_with_spill.sv; expects clk and rst_n in scope.
`ifndef REGISTER_POOL_ALLOCATOR_WITH_SPILL_DEFINES_SVH
`define REGISTER_POOL_ALLOCATOR_WITH_SPILL_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a condition at every edge outside reset.
`define RPA_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle.
`define RPA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define RPA_ASSERT(lbl, cond, msg)
`define RPA_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

@@ design/rpa_pkg.sv @@
// Package for the register pool allocator: opcodes, sequencer states, defaults.
// No dependencies.
`default_nettype none

package rpa_pkg;

    localparam int NUM_REGS_DEF = 32;
    localparam int VAR_BITS_DEF = 16;
    localparam int POS_BITS_DEF = 16;
    localparam int AGE_W        = 32;

    typedef enum logic [2:0] {
        OP_ALLOC_VAR = 3'd0,
        OP_ALLOC_TMP = 3'd1,
        OP_RESERVE   = 3'd2,
        OP_FREE_VAR  = 3'd3,
        OP_FREE_REG  = 3'd4,
        OP_RESET     = 3'd5
    } rpa_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } rpa_state_t;

endpackage

`default_nettype wire

@@ design/register_pool_allocator_with_spill.sv @@
// Register pool allocator with spill: integer and float pools, binding store, sequencer.
// Depends on rpa_pkg and register_pool_allocator_with_spill_defines.svh.
//
// Usage:
//   Request channel (item_valid / item_stall) carries one operation: alloc var,
//   alloc temp, reserve, free var, free reg or reset, with its class, variable id,
//   live range and an optional register number. Result channel (result_valid /
//   result_stall) returns ok, the register, spill info and the class's used map.
//   Each request walks the NUM_REGS binding entries of its class through the single
//   read port of the binding memory, one entry per cycle, feeding one shared
//   compare unit that tracks the bound variable, the lowest free register and the
//   spill candidate. The result is loaded into the output register at the commit
//   step, after the scan and the drain step, and the next request is taken once
//   the sequencer is back in idle. item_stall is high while a request is in flight.
//   The result sits in an output register; a new request is accepted while it
//   waits, and that request holds in its commit step until the result register
//   frees. Reset clears the occupied and used maps, the binding valid bits and
//   the age counter at once; the binding memory itself is not cleared since an
//   entry is read only while its valid bit is set.
`default_nettype none
`include "register_pool_allocator_with_spill_defines.svh"

module register_pool_allocator_with_spill
    import rpa_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF,
    parameter int VAR_BITS = VAR_BITS_DEF,
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [2:0]  opcode,
    input  wire logic        fp_class,
    input  wire logic [15:0] var_id,
    input  wire logic [15:0] live_begin,
    input  wire logic [15:0] live_end,
    input  wire logic        req_valid,
    input  wire logic [4:0]  req_reg,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             ok,
    output logic [4:0]       reg_res,
    output logic             spilled,
    output logic [15:0]      spill_var,
    output logic [31:0]      used_map
);

    localparam int RW = $clog2(NUM_REGS);
    localparam int NB = 2 * NUM_REGS;
    localparam int AW = $clog2(NB);
    localparam int MW = AGE_W + POS_BITS + VAR_BITS;

    // Sequencer
    rpa_state_t state_reg, state_next;
    logic       scan_issue;
    logic       commit_go;
    logic       scan_last;

    // Request held for the whole operation
    logic [2:0]          op_reg;
    logic                cls_reg;
    logic [VAR_BITS-1:0] var_reg;
    logic [POS_BITS-1:0] lb_reg;
    logic [POS_BITS-1:0] le_reg;
    logic                req_ok_reg;
    logic [RW-1:0]       req_idx_reg;

    // Input narrowing / widening
    logic [47:0]         var_wide;
    logic [47:0]         lb_wide;
    logic [47:0]         le_wide;
    logic [RW+4:0]       req_wide;
    logic                req_ok_in;

    // Pool state
    logic [NUM_REGS-1:0] occ_reg [0:1];
    logic [NUM_REGS-1:0] occ_next [0:1];
    logic [NUM_REGS-1:0] used_reg [0:1];
    logic [NUM_REGS-1:0] used_next [0:1];
    logic [NB-1:0]       bv_reg;
    logic [NB-1:0]       bv_next;
    logic [AGE_W-1:0]    age_cnt_reg;
    logic [AGE_W-1:0]    age_next;

    // Binding memory
    logic [MW-1:0]       bind_mem [0:NB-1];
    logic [MW-1:0]       rd_data_reg;
    logic                mem_we;
    logic [AW-1:0]       waddr;
    logic [MW-1:0]       wdata;
    logic [AW-1:0]       scan_addr;

    // Scan counter and read stage
    logic [RW-1:0]       cnt_reg;
    logic                p1_valid_reg;
    logic [RW-1:0]       p1_idx_reg;
    logic                p1_bv_reg;
    logic                p1_occ_reg;

    // Shared compare unit
    logic [VAR_BITS-1:0] mem_var;
    logic [POS_BITS-1:0] mem_end;
    logic [AGE_W-1:0]    mem_age;
    logic [AGE_W-1:0]    age_gap;
    logic                var_match;
    logic                cand_ok;
    logic                better;

    // Search results
    logic                found_reg;
    logic [RW-1:0]       found_idx_reg;
    logic                free_found_reg;
    logic [RW-1:0]       free_idx_reg;
    logic                best_found_reg;
    logic [RW-1:0]       best_idx_reg;
    logic [POS_BITS-1:0] best_end_reg;
    logic [AGE_W-1:0]    best_dist_reg;
    logic [VAR_BITS-1:0] best_var_reg;
    logic [VAR_BITS-1:0] hit_var_reg;

    // Commit decision
    logic                req_free;
    logic                can_alloc;
    logic                do_spill;
    logic [RW-1:0]       chosen_idx;
    logic [AW-1:0]       chosen_addr;
    logic [AW-1:0]       req_addr;
    logic [AW-1:0]       found_addr;
    logic                ok_next;
    logic [RW-1:0]       res_idx;
    logic                sp_next;
    logic [VAR_BITS-1:0] sv_next;
    logic [RW+4:0]       res_wide;
    logic [VAR_BITS+15:0] sv_wide;
    logic [NUM_REGS+31:0] used_wide;

    // Result register
    logic                result_valid_reg;
    logic                ok_reg;
    logic [4:0]          reg_res_reg;
    logic                spilled_reg;
    logic [15:0]         spill_var_reg;
    logic [31:0]         used_map_reg;

    function automatic logic [AW-1:0] ent_addr(input logic cls, input logic [RW-1:0] idx);
        logic [AW-1:0] base;
        base = cls ? AW'(NUM_REGS) : '0;
        return base + AW'(idx);
    endfunction

    // Fit request fields to the configured widths
    assign var_wide  = {32'd0, var_id};
    assign lb_wide   = {32'd0, live_begin};
    assign le_wide   = {32'd0, live_end};
    assign req_wide  = {{RW{1'b0}}, req_reg};
    assign req_ok_in = req_valid && ({27'd0, req_reg} < 32'(NUM_REGS));

    // ---------------------------------------------------------------
    // Sequencer: idle -> scan every entry -> drain read stage -> commit
    // ---------------------------------------------------------------
    assign scan_last = (cnt_reg == RW'(NUM_REGS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall = 1'b1;
        scan_issue = 1'b0;
        commit_go  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   item_stall = 1'b0;
            ST_SCAN:   scan_issue = 1'b1;
            ST_DRAIN:  ;
            ST_COMMIT: commit_go = !result_valid_reg || !result_stall;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Latch the request on acceptance
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            op_reg      <= opcode;
            cls_reg     <= fp_class;
            var_reg     <= var_wide[VAR_BITS-1:0];
            lb_reg      <= lb_wide[POS_BITS-1:0];
            le_reg      <= le_wide[POS_BITS-1:0];
            req_ok_reg  <= req_ok_in;
            req_idx_reg <= req_wide[RW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Scan: one binding entry per cycle through the memory read port
    // ---------------------------------------------------------------
    assign scan_addr = ent_addr(cls_reg, cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                cnt_reg <= '0;
            end
            else if (scan_issue && !scan_last)
            begin
                cnt_reg <= cnt_reg + RW'(1);
            end
            p1_valid_reg <= scan_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg <= cnt_reg;
        p1_bv_reg  <= bv_reg[scan_addr];
        p1_occ_reg <= occ_reg[cls_reg][cnt_reg];
    end

    // Binding memory: one write port at commit, one registered read port for the scan
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bind_mem[waddr] <= wdata;
        end
        rd_data_reg <= bind_mem[scan_addr];
    end

    // Shared compare unit on the entry just read
    assign mem_var   = rd_data_reg[VAR_BITS-1:0];
    assign mem_end   = rd_data_reg[VAR_BITS+POS_BITS-1:VAR_BITS];
    assign mem_age   = rd_data_reg[MW-1:VAR_BITS+POS_BITS];
    assign age_gap   = age_cnt_reg - mem_age;
    assign var_match = p1_bv_reg && (mem_var == var_reg);
    assign cand_ok   = p1_bv_reg && ((op_reg != OP_ALLOC_VAR) || (mem_end <= lb_reg));
    assign better    = !best_found_reg || (mem_end < best_end_reg) ||
                       ((mem_end == best_end_reg) && (age_gap > best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else if (item_valid && !item_stall)
        begin
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else if (p1_valid_reg)
        begin
            // Ascending scan: keep the first match and the first free register
            if (!found_reg && var_match)
            begin
                found_reg <= 1'b1;
            end
            if (!free_found_reg && !p1_occ_reg)
            begin
                free_found_reg <= 1'b1;
            end
            if (cand_ok && better)
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            if (!found_reg && var_match)
            begin
                found_idx_reg <= p1_idx_reg;
            end
            if (!free_found_reg && !p1_occ_reg)
            begin
                free_idx_reg <= p1_idx_reg;
            end
            if (cand_ok && better)
            begin
                best_idx_reg  <= p1_idx_reg;
                best_end_reg  <= mem_end;
                best_dist_reg <= age_gap;
                best_var_reg  <= mem_var;
            end
            if (p1_idx_reg == req_idx_reg)
            begin
                hit_var_reg <= mem_var;
            end
        end
    end

    // ---------------------------------------------------------------
    // Commit: pick the register, update maps and bindings, load result
    // ---------------------------------------------------------------
    assign req_free    = req_ok_reg && !occ_reg[cls_reg][req_idx_reg];
    assign can_alloc   = req_free || free_found_reg || best_found_reg;
    assign do_spill    = !req_free && !free_found_reg;
    assign chosen_idx  = req_free ? req_idx_reg : (free_found_reg ? free_idx_reg : best_idx_reg);
    assign chosen_addr = ent_addr(cls_reg, chosen_idx);
    assign req_addr    = ent_addr(cls_reg, req_idx_reg);
    assign found_addr  = ent_addr(cls_reg, found_idx_reg);

    always_comb
    begin
        occ_next[0]  = occ_reg[0];
        occ_next[1]  = occ_reg[1];
        used_next[0] = used_reg[0];
        used_next[1] = used_reg[1];
        bv_next      = bv_reg;
        age_next     = age_cnt_reg;
        mem_we       = 1'b0;
        waddr        = chosen_addr;
        wdata        = {age_cnt_reg, le_reg, var_reg};
        ok_next      = 1'b0;
        res_idx      = '0;
        sp_next      = 1'b0;
        sv_next      = '0;
        if (commit_go)
        begin
            unique case (op_reg)
                OP_ALLOC_VAR, OP_ALLOC_TMP:
                begin
                    if ((op_reg == OP_ALLOC_VAR) && found_reg)
                    begin
                        // Already bound: hand back the same register
                        ok_next = 1'b1;
                        res_idx = found_idx_reg;
                    end
                    else if (can_alloc)
                    begin
                        if (do_spill)
                        begin
                            sp_next              = 1'b1;
                            sv_next              = best_var_reg;
                            bv_next[chosen_addr] = 1'b0;
                        end
                        occ_next[cls_reg][chosen_idx]  = 1'b1;
                        used_next[cls_reg][chosen_idx] = 1'b1;
                        if (op_reg == OP_ALLOC_VAR)
                        begin
                            bv_next[chosen_addr] = 1'b1;
                            mem_we               = 1'b1;
                            age_next             = age_cnt_reg + AGE_W'(1);
                        end
                        ok_next = 1'b1;
                        res_idx = chosen_idx;
                    end
                end
                OP_RESERVE:
                begin
                    if (req_ok_reg)
                    begin
                        if (occ_reg[cls_reg][req_idx_reg] && bv_reg[req_addr])
                        begin
                            sp_next           = 1'b1;
                            sv_next           = hit_var_reg;
                            bv_next[req_addr] = 1'b0;
                        end
                        occ_next[cls_reg][req_idx_reg]  = 1'b1;
                        used_next[cls_reg][req_idx_reg] = 1'b1;
                        ok_next = 1'b1;
                        res_idx = req_idx_reg;
                    end
                end
                OP_FREE_VAR:
                begin
                    if (found_reg)
                    begin
                        occ_next[cls_reg][found_idx_reg] = 1'b0;
                        bv_next[found_addr]              = 1'b0;
                        ok_next = 1'b1;
                        res_idx = found_idx_reg;
                    end
                end
                OP_FREE_REG:
                begin
                    if (req_ok_reg)
                    begin
                        occ_next[cls_reg][req_idx_reg] = 1'b0;
                        bv_next[req_addr]              = 1'b0;
                        ok_next = 1'b1;
                        res_idx = req_idx_reg;
                    end
                end
                OP_RESET:
                begin
                    // Drop both classes; used maps stay
                    occ_next[0] = '0;
                    occ_next[1] = '0;
                    bv_next     = '0;
                    ok_next     = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg[0]  <= '0;
            occ_reg[1]  <= '0;
            used_reg[0] <= '0;
            used_reg[1] <= '0;
            bv_reg      <= '0;
            age_cnt_reg <= '0;
        end
        else if (commit_go)
        begin
            occ_reg[0]  <= occ_next[0];
            occ_reg[1]  <= occ_next[1];
            used_reg[0] <= used_next[0];
            used_reg[1] <= used_next[1];
            bv_reg      <= bv_next;
            age_cnt_reg <= age_next;
        end
    end

    // Result register
    assign res_wide  = {5'd0, res_idx};
    assign sv_wide   = {16'd0, sv_next};
    assign used_wide = {32'd0, used_next[cls_reg]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (commit_go)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit_go)
        begin
            ok_reg        <= ok_next;
            reg_res_reg   <= res_wide[4:0];
            spilled_reg   <= sp_next;
            spill_var_reg <= sv_wide[15:0];
            used_map_reg  <= used_wide[31:0];
        end
    end

    assign result_valid = result_valid_reg;
    assign ok           = ok_reg;
    assign reg_res      = reg_res_reg;
    assign spilled      = spilled_reg;
    assign spill_var    = spill_var_reg;
    assign used_map     = used_map_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `RPA_ASSERT(a_occ_in_used, ((occ_reg[0] & ~used_reg[0]) == '0) && ((occ_reg[1] & ~used_reg[1]) == '0), "occupied register missing from used map")
    `RPA_ASSERT_IMPL(a_spill_ok, result_valid && spilled, ok, "spill reported on a failed request")
    `RPA_ASSERT_IMPL(a_age_on_commit, age_cnt_reg != $past(age_cnt_reg), $past(commit_go), "age counter moved outside commit")
    `RPA_ASSERT_IMPL(a_idle_quiet, state_reg == ST_IDLE, !p1_valid_reg, "scan read stage busy while idle")

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for register_pool_allocator_with_spill.
// Depends on rpa_pkg and the design files; predicts every result in the bench itself.
`default_nettype none

module tb
    import rpa_pkg::*;
();

    localparam int NREGS = NUM_REGS_DEF;
    localparam int WATCHDOG_LIMIT = 3000;

    // Opcodes the block must ignore.
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        fp_class;
        logic [15:0] var_id;
        logic [15:0] live_begin;
        logic [15:0] live_end;
        logic        req_valid;
        logic [4:0]  req_reg;
    } alloc_req_t;

    typedef struct packed {
        logic        ok;
        logic [4:0]  reg_res;
        logic        spilled;
        logic [15:0] spill_var;
        logic [31:0] used_map;
    } alloc_res_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [2:0]  opcode;
    logic        fp_class;
    logic [15:0] var_id;
    logic [15:0] live_begin;
    logic [15:0] live_end;
    logic        req_valid;
    logic [4:0]  req_reg;
    logic        result_valid;
    logic        result_stall;
    logic        ok;
    logic [4:0]  reg_res;
    logic        spilled;
    logic [15:0] spill_var;
    logic [31:0] used_map;

    register_pool_allocator_with_spill dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .opcode       (opcode),
        .fp_class     (fp_class),
        .var_id       (var_id),
        .live_begin   (live_begin),
        .live_end     (live_end),
        .req_valid    (req_valid),
        .req_reg      (req_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ok           (ok),
        .reg_res      (reg_res),
        .spilled      (spilled),
        .spill_var    (spill_var),
        .used_map     (used_map)
    );

    // Shadow copy of the pools and the binding store, indexed class*NREGS+reg.
    logic [31:0] pool_occ  [0:1];
    logic [31:0] pool_used [0:1];
    logic        bnd_live  [0:2*NREGS-1];
    logic [15:0] bnd_var   [0:2*NREGS-1];
    logic [15:0] bnd_end   [0:2*NREGS-1];
    logic [31:0] bnd_age   [0:2*NREGS-1];
    logic [31:0] age_next;

    alloc_res_t pending_results[$];
    int         mismatch_count;
    int         error_count;
    bit         steady;     // when set, neither side idles

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int find_bound(int c, logic [15:0] v);
        int hit;
        hit = -1;
        for (int r = NREGS - 1; r >= 0; r--)
            if (bnd_live[c*NREGS+r] && bnd_var[c*NREGS+r] == v)
                hit = r;
        return hit;
    endfunction

    // Compute the result of one request and advance the shadow state.
    function automatic alloc_res_t predict_alloc(alloc_req_t q);
        alloc_res_t  o;
        int          c;
        int          hit;
        int          chosen;
        int          best;
        int          idx;
        logic [15:0] best_end;
        logic [31:0] best_dist;
        logic [31:0] age_gap;
        o = '0;
        c = q.fp_class;
        hit = -1;
        chosen = -1;
        best = -1;
        best_end = '0;
        best_dist = '0;
        case (q.opcode)
            OP_ALLOC_VAR, OP_ALLOC_TMP:
            begin
                if (q.opcode == OP_ALLOC_VAR)
                    hit = find_bound(c, q.var_id);
                if (hit >= 0)
                begin
                    o.ok = 1'b1;
                    o.reg_res = hit[4:0];
                end
                else
                begin
                    if (q.req_valid && !pool_occ[c][q.req_reg])
                        chosen = int'(q.req_reg);
                    else
                        for (int r = 0; r < NREGS && chosen < 0; r++)
                            if (!pool_occ[c][r])
                                chosen = r;
                    if (chosen < 0)
                    begin
                        // Pick the earliest live end; on a tie the oldest binding.
                        for (int r = 0; r < NREGS; r++)
                        begin
                            idx = c*NREGS + r;
                            if (bnd_live[idx] &&
                                !(q.opcode == OP_ALLOC_VAR && bnd_end[idx] > q.live_begin))
                            begin
                                age_gap = age_next - bnd_age[idx];
                                if (best < 0 || bnd_end[idx] < best_end ||
                                    (bnd_end[idx] == best_end && age_gap > best_dist))
                                begin
                                    best = r;
                                    best_end = bnd_end[idx];
                                    best_dist = age_gap;
                                end
                            end
                        end
                        if (best >= 0)
                        begin
                            idx = c*NREGS + best;
                            o.spilled = 1'b1;
                            o.spill_var = bnd_var[idx];
                            bnd_live[idx] = 1'b0;
                            chosen = best;
                        end
                    end
                    if (chosen >= 0)
                    begin
                        pool_occ[c][chosen] = 1'b1;
                        pool_used[c][chosen] = 1'b1;
                        if (q.opcode == OP_ALLOC_VAR)
                        begin
                            idx = c*NREGS + chosen;
                            bnd_live[idx] = 1'b1;
                            bnd_var[idx] = q.var_id;
                            bnd_end[idx] = q.live_end;
                            bnd_age[idx] = age_next;
                            age_next = age_next + 32'd1;
                        end
                        o.ok = 1'b1;
                        o.reg_res = chosen[4:0];
                    end
                end
            end
            OP_RESERVE:
            begin
                if (q.req_valid)
                begin
                    idx = c*NREGS + q.req_reg;
                    if (pool_occ[c][q.req_reg] && bnd_live[idx])
                    begin
                        o.spilled = 1'b1;
                        o.spill_var = bnd_var[idx];
                        bnd_live[idx] = 1'b0;
                    end
                    pool_occ[c][q.req_reg] = 1'b1;
                    pool_used[c][q.req_reg] = 1'b1;
                    o.ok = 1'b1;
                    o.reg_res = q.req_reg;
                end
            end
            OP_FREE_VAR:
            begin
                hit = find_bound(c, q.var_id);
                if (hit >= 0)
                begin
                    pool_occ[c][hit] = 1'b0;
                    bnd_live[c*NREGS+hit] = 1'b0;
                    o.ok = 1'b1;
                    o.reg_res = hit[4:0];
                end
            end
            OP_FREE_REG:
            begin
                if (q.req_valid)
                begin
                    pool_occ[c][q.req_reg] = 1'b0;
                    bnd_live[c*NREGS+q.req_reg] = 1'b0;
                    o.ok = 1'b1;
                    o.reg_res = q.req_reg;
                end
            end
            OP_RESET:
            begin
                // Clear both classes whatever the class bit says; keep the used maps.
                pool_occ[0] = '0;
                pool_occ[1] = '0;
                for (int i = 0; i < 2*NREGS; i++)
                    bnd_live[i] = 1'b0;
                o.ok = 1'b1;
            end
            default: ;
        endcase
        o.used_map = pool_used[c];
        return o;
    endfunction

    function automatic alloc_req_t make_req(int unsigned op, int unsigned cls,
                                            int unsigned v, int unsigned lb,
                                            int unsigned le, int unsigned rv,
                                            int unsigned rr);
        alloc_req_t q;
        q.opcode = op[2:0];
        q.fp_class = cls[0];
        q.var_id = v[15:0];
        q.live_begin = lb[15:0];
        q.live_end = le[15:0];
        q.req_valid = rv[0];
        q.req_reg = rr[4:0];
        return q;
    endfunction

    // Mostly short gaps, a few long ones; none while steady.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Drive one request, hold it until accepted, then queue its expected result.
    task automatic send_req(alloc_req_t q);
        int  gap;
        bit  taken;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        opcode     <= q.opcode;
        fp_class   <= q.fp_class;
        var_id     <= q.var_id;
        live_begin <= q.live_begin;
        live_end   <= q.live_end;
        req_valid  <= q.req_valid;
        req_reg    <= q.req_reg;
        item_valid <= 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !item_stall;
        end
        pending_results.insert(pending_results.size(), predict_alloc(q));
    endtask

    // Hold off the sender until every queued result has come back.
    task automatic drain_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver side: stall at random, never while steady.
    initial
    begin
        int hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (steady)
            begin
                hold = 0;
                result_stall <= 1'b0;
            end
            else if (hold > 0)
            begin
                hold = hold - 1;
                result_stall <= 1'b1;
            end
            else
            begin
                hold = pick_gap();
                if (hold > 0)
                begin
                    hold = hold - 1;
                    result_stall <= 1'b1;
                end
                else
                    result_stall <= 1'b0;
            end
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        alloc_res_t exp_res;
        alloc_res_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got = {ok, reg_res, spilled, spill_var, used_map};
            if (pending_results.size() == 0)
            begin
                error_count = error_count + 1;
                if (error_count + mismatch_count <= 10)
                    $display("unexpected result: ok=%0d reg=%0d spilled=%0d var=%h used=%h",
                             ok, reg_res, spilled, spill_var, used_map);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (got.ok !== exp_res.ok || got.reg_res !== exp_res.reg_res ||
                    got.spilled !== exp_res.spilled || got.spill_var !== exp_res.spill_var ||
                    got.used_map !== exp_res.used_map)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (error_count + mismatch_count <= 10)
                        $display("mismatch: exp ok=%0d reg=%0d sp=%0d var=%h used=%h | got ok=%0d reg=%0d sp=%0d var=%h used=%h",
                                 exp_res.ok, exp_res.reg_res, exp_res.spilled,
                                 exp_res.spill_var, exp_res.used_map,
                                 got.ok, got.reg_res, got.spilled, got.spill_var,
                                 got.used_map);
                end
            end
        end
    end

    // Watchdog: end the run once nothing moves on either channel for too long.
    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall) || !rst_n)
                idle = 0;
            else
                idle = idle + 1;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Corner cases: reset, ignored opcodes, missing register, extremes of every field.
    task automatic test_directed();
        send_req(make_req(OP_RESET,     1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 5'd0));
        send_req(make_req(OP_UNUSED_6,  1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 5'd31));
        send_req(make_req(OP_UNUSED_7,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 5'd0));
        send_req(make_req(OP_RESERVE,   1'b0, 16'h1234, 16'h0000, 16'h0000, 1'b0, 5'd7));
        send_req(make_req(OP_FREE_REG,  1'b1, 16'h1234, 16'h0000, 16'h0000, 1'b0, 5'd7));
        send_req(make_req(OP_FREE_VAR,  1'b0, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 5'd0));
        // Bind at the requested top register, then hit the existing binding.
        send_req(make_req(OP_ALLOC_VAR, 1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 5'd31));
        send_req(make_req(OP_ALLOC_VAR, 1'b0, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 5'd3));
        send_req(make_req(OP_ALLOC_VAR, 1'b0, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 5'd31));
        // Requested register taken: fall back to the lowest free one.
        send_req(make_req(OP_ALLOC_TMP, 1'b0, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, 5'd31));
        send_req(make_req(OP_ALLOC_TMP, 1'b1, 16'h5555, 16'hAAAA, 16'h5555, 1'b1, 5'd0));
        // Reserve a bound register: its variable is reported as spilled.
        send_req(make_req(OP_RESERVE,   1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 5'd0));
        send_req(make_req(OP_RESERVE,   1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1, 5'd5));
        send_req(make_req(OP_FREE_REG,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 5'd1));
        send_req(make_req(OP_FREE_VAR,  1'b0, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 5'd0));
        send_req(make_req(OP_FREE_VAR,  1'b1, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 5'd0));
        send_req(make_req(OP_ALLOC_VAR, 1'b1, 16'h5A5A, 16'h00FF, 16'hFF00, 1'b1, 5'd0));
        // Reset through the float class clears the integer pool too.
        send_req(make_req(OP_RESET,     1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 5'd31));
        send_req(make_req(OP_ALLOC_TMP, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 5'd31));
        send_req(make_req(OP_FREE_REG,  1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1, 5'd31));
    endtask

    // Fill one pool, then probe spill choice, live-range limits and age ties.
    task automatic test_spill_rounds();
        logic        cls;
        logic [15:0] base;
        logic [15:0] v;
        int          sel;
        for (int round = 0; round < 10; round++)
        begin
            send_req(make_req(OP_RESET, $urandom_range(0, 1), $urandom(), $urandom(),
                              $urandom(), 1'b0, $urandom()));
            cls = 1'($urandom_range(0, 1));
            base = 16'($urandom());
            steady = (round == 3);
            for (int k = 0; k < NREGS; k++)
            begin
                // Round zero fills with temporaries only: nothing can be spilled.
                if (round == 0 || $urandom_range(0, 7) == 0)
                    send_req(make_req(OP_ALLOC_TMP, cls, $urandom(), $urandom(), $urandom(),
                                      $urandom_range(0, 3) == 0, $urandom()));
                else
                    send_req(make_req(OP_ALLOC_VAR, cls, base + k, k,
                                      $urandom_range(0, 7) * 8,
                                      $urandom_range(0, 3) == 0, $urandom()));
            end
            for (int p = 0; p < 8; p++)
            begin
                sel = $urandom_range(0, 5);
                v = 16'(base + $urandom_range(0, NREGS - 1));
                case (sel)
                    0: send_req(make_req(OP_ALLOC_VAR, cls, base + 16'd40 + p,
                                         $urandom_range(0, 63), $urandom(),
                                         $urandom_range(0, 1), $urandom()));
                    1: send_req(make_req(OP_ALLOC_TMP, cls, $urandom(), $urandom(),
                                         $urandom(), $urandom_range(0, 1), $urandom()));
                    2: send_req(make_req(OP_RESERVE, cls, $urandom(), $urandom(),
                                         $urandom(), 1'b1, $urandom()));
                    3: send_req(make_req(OP_ALLOC_VAR, cls, v, $urandom_range(0, 63),
                                         $urandom(), $urandom_range(0, 1), $urandom()));
                    4: send_req(make_req(OP_FREE_VAR, cls, v, $urandom(), $urandom(),
                                         $urandom_range(0, 1), $urandom()));
                    default: send_req(make_req(OP_ALLOC_VAR, cls, $urandom(), 16'hFFFF,
                                               $urandom(), $urandom_range(0, 1),
                                               $urandom()));
                endcase
            end
        end
        steady = 1'b0;
    endtask

    // Linear-scan traffic: advancing positions, a small set of variables, mixed ops.
    task automatic test_linear_scan(int count);
        logic [15:0] pos;
        logic [15:0] base;
        logic        main_cls;
        logic        cls;
        logic [15:0] v;
        int          r;
        pos = 16'($urandom());
        base = 16'($urandom());
        main_cls = 1'b0;
        for (int n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
            begin
                main_cls = 1'($urandom_range(0, 1));
                base = 16'($urandom());
                steady = ($urandom_range(0, 5) == 0);
            end
            if (n == count / 2)
                drain_results();
            cls = ($urandom_range(0, 3) == 0) ? ~main_cls : main_cls;
            v = 16'(base + $urandom_range(0, 47));
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                send_req(make_req(OP_ALLOC_VAR, cls, v, pos, pos + $urandom_range(0, 400),
                                  $urandom_range(0, 1), $urandom()));
                pos = 16'(pos + $urandom_range(0, 20));
            end
            else if (r < 50)
                send_req(make_req(OP_ALLOC_TMP, cls, $urandom(), $urandom(), $urandom(),
                                  $urandom_range(0, 1), $urandom()));
            else if (r < 57)
                send_req(make_req(OP_RESERVE, cls, $urandom(), $urandom(), $urandom(),
                                  $urandom_range(0, 7) != 0, $urandom()));
            else if (r < 72)
                send_req(make_req(OP_FREE_VAR, cls, v, $urandom(), $urandom(),
                                  $urandom_range(0, 1), $urandom()));
            else if (r < 82)
                send_req(make_req(OP_FREE_REG, cls, $urandom(), $urandom(), $urandom(),
                                  $urandom_range(0, 7) != 0, $urandom()));
            else if (r < 84)
                send_req(make_req(OP_RESET, cls, $urandom(), $urandom(), $urandom(),
                                  $urandom_range(0, 1), $urandom()));
            else if (r < 86)
                send_req(make_req(($urandom_range(0, 1) != 0) ? OP_UNUSED_6 : OP_UNUSED_7,
                                  cls, $urandom(), $urandom(), $urandom(),
                                  $urandom_range(0, 1), $urandom()));
            else
            begin
                // Jump ahead so that older bindings qualify for a spill.
                pos = 16'(pos + $urandom_range(100, 600));
                send_req(make_req(OP_ALLOC_VAR, cls, v, pos, pos + $urandom_range(0, 400),
                                  $urandom_range(0, 1), $urandom()));
            end
        end
        steady = 1'b0;
    endtask

    // Fully random fields, every opcode code included.
    task automatic test_noise(int count);
        for (int n = 0; n < count; n++)
            send_req(make_req($urandom_range(0, 7), $urandom_range(0, 1), $urandom(),
                              $urandom(), $urandom(), $urandom_range(0, 1), $urandom()));
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        opcode = OP_ALLOC_VAR;
        fp_class = 1'b0;
        var_id = '0;
        live_begin = '0;
        live_end = '0;
        req_valid = 1'b0;
        req_reg = '0;
        result_stall = 1'b0;
        steady = 1'b0;
        mismatch_count = 0;
        error_count = 0;
        pool_occ[0] = '0;
        pool_occ[1] = '0;
        pool_used[0] = '0;
        pool_used[1] = '0;
        age_next = '0;
        for (int i = 0; i < 2*NREGS; i++)
        begin
            bnd_live[i] = 1'b0;
            bnd_var[i] = '0;
            bnd_end[i] = '0;
            bnd_age[i] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        drain_results();
        test_spill_rounds();
        test_linear_scan(700);
        test_noise(150);

        // Let the last results arrive, then watch for strays.
        drain_results();
        repeat (2*NREGS + 8) @(posedge clk);
        if (mismatch_count == 0 && error_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
